FILE: rtl/core/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

    // Item class decided by the front end.
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,  // full word in the middle of a message
        KIND_LAST_FULL = 2'd1,  // final word with four bytes, marker word still due
        KIND_LAST_PART = 2'd2   // final word with the marker byte already merged in
    } t_kind;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  add_bits;
        t_kind       kind;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_out;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] PAD_WORD = {PAD_BYTE, 24'h000000};

    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [3:0] LEN_HI_SLOT = 4'd14;
    localparam logic [3:0] LAST_SLOT   = 4'd15;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_INDEX  = 3'd4;

endpackage

FILE: rtl/core/sha1_message_digest_unit.sv
`timescale 1ns / 1ps

// SHA-1 digest of a byte message streamed as big-endian 32-bit words.
// Input channel (s_axis): tdata is the message word with its first byte in
// bits 31..24, tuser the count of valid leading bytes (0..4, below 4 only on
// the last word) and tlast marks the final word of a message.
// Output channel (m_axis): five items per message, tdata a digest word,
// tuser its position (0 most significant) and tlast set on the fifth.
// Each 16-word block is shifted from the queue into the schedule window,
// then compressed by the single round unit, one round per cycle, and
// closed by the chaining add; the engine pops no word meanwhile. After
// the final word the engine appends the padding words itself, compresses
// one or two blocks, then presents the five digest words in order.
// A queue of QUEUE_DEPTH items sits in front of the engine, so input is
// still taken while a block is compressed or digest words wait.
// When the receiver stalls, the current digest word holds and the engine
// waits; input keeps flowing until the queue fills.
// Reset clears the queue, the length and fill counts and loads the
// standard initial chaining values; the next word starts a new message.

module sha1_message_digest_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] message_word
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] valid_bytes
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    sha1_pkg::t_entry q_in;
    sha1_pkg::t_q_out q_out;

    sha1_front u_front (
        .i_valid  (i_s_axis_tvalid),
        .i_word   (i_s_axis_tdata),
        .i_nbytes (i_s_axis_tuser),
        .i_final  (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    sha1_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_q     (q_out)
    );

    sha1_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (q_out),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: rtl/core/sha1_front.sv
`timescale 1ns / 1ps

module sha1_front (
    input  logic               i_valid,
    input  logic [31:0]        i_word,
    input  logic [2:0]         i_nbytes,
    input  logic               i_final,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output sha1_pkg::t_entry   o_entry
);

    logic [2:0]  nb;
    logic [31:0] mask;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Counts above four on a final word are taken as four.
    assign nb = (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;

    always_comb begin
        unique case (nb)
            3'd0:    mask = 32'h00000000;
            3'd1:    mask = 32'hff000000;
            3'd2:    mask = 32'hffff0000;
            3'd3:    mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
    end

    always_comb begin
        if (!i_final) begin
            o_entry.word     = i_word;
            o_entry.add_bits = 6'd32;
            o_entry.kind     = sha1_pkg::KIND_DATA;
        end else if (nb == 3'd4) begin
            o_entry.word     = i_word;
            o_entry.add_bits = 6'd32;
            o_entry.kind     = sha1_pkg::KIND_LAST_FULL;
        end else begin
            // The marker byte lands right after the last valid byte.
            o_entry.word     = (i_word & mask) | (sha1_pkg::PAD_WORD >> {nb, 3'b000});
            o_entry.add_bits = {nb, 3'b000};
            o_entry.kind     = sha1_pkg::KIND_LAST_PART;
        end
    end

endmodule

FILE: rtl/core/sha1_fifo.sv
`timescale 1ns / 1ps

module sha1_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sha1_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output sha1_pkg::t_q_out o_q
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sha1_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_q.valid  = (r_cnt != '0);
    assign o_q.entry  = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_q.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: rtl/core/sha1_engine.sv
`timescale 1ns / 1ps

module sha1_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha1_pkg::t_q_out i_q,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [31:0]      o_tdata,
    output logic [2:0]       o_tuser,
    output logic             o_tlast
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PH_NONE   = 4'b0001,
        PH_MARK   = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_LEN_LO = 4'b1000
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_fill, n_fill;
    logic [6:0]  r_round, n_round;
    logic [63:0] r_bitlen, n_bitlen;
    logic        r_finish, n_finish;
    logic [2:0]  r_oidx, n_oidx;
    logic [31:0] r_h [5];
    logic [31:0] n_h [5];
    logic [31:0] r_v [5];
    logic [31:0] n_v [5];
    logic [31:0] r_win [16];

    logic        push;
    logic [31:0] push_word;
    logic [31:0] fn, kc, tmp, sched;
    logic        win_shift;
    logic [31:0] win_in;

    // The window shifts by one word per push and per round; slot 0 is W[t].
    assign sched = {r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]} << 1
                 | {r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]} >> 31;

    always_comb begin
        if (r_round < 7'd20) begin
            fn = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            kc = sha1_pkg::K0;
        end else if (r_round < 7'd40) begin
            fn = r_v[1] ^ r_v[2] ^ r_v[3];
            kc = sha1_pkg::K1;
        end else if (r_round < 7'd60) begin
            fn = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            kc = sha1_pkg::K2;
        end else begin
            fn = r_v[1] ^ r_v[2] ^ r_v[3];
            kc = sha1_pkg::K3;
        end
        tmp = {r_v[0][26:0], r_v[0][31:27]} + fn + r_v[4] + kc + r_win[0];
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_fill    = r_fill;
        n_round   = r_round;
        n_bitlen  = r_bitlen;
        n_finish  = r_finish;
        n_oidx    = r_oidx;
        n_h       = r_h;
        n_v       = r_v;
        push      = 1'b0;
        push_word = '0;
        o_pop     = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                unique case (r_phase)
                    PH_NONE: begin
                        if (i_q.valid) begin
                            o_pop     = 1'b1;
                            push      = 1'b1;
                            push_word = i_q.entry.word;
                            n_bitlen  = r_bitlen + {58'd0, i_q.entry.add_bits};
                            unique case (i_q.entry.kind)
                                sha1_pkg::KIND_LAST_FULL: n_phase = PH_MARK;
                                sha1_pkg::KIND_LAST_PART: n_phase = PH_ZERO;
                                default:                  n_phase = PH_NONE;
                            endcase
                        end
                    end
                    PH_MARK: begin
                        push      = 1'b1;
                        push_word = sha1_pkg::PAD_WORD;
                        n_phase   = PH_ZERO;
                    end
                    PH_ZERO: begin
                        push = 1'b1;
                        if (r_fill == sha1_pkg::LEN_HI_SLOT) begin
                            push_word = r_bitlen[63:32];
                            n_phase   = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        push      = 1'b1;
                        push_word = r_bitlen[31:0];
                        n_phase   = PH_NONE;
                        n_finish  = 1'b1;
                    end
                    default: n_phase = PH_NONE;
                endcase
                if (push) begin
                    n_fill = r_fill + 1'b1;
                    if (r_fill == sha1_pkg::LAST_SLOT) begin
                        n_v     = r_h;
                        n_round = '0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                n_v[4]  = r_v[3];
                n_v[3]  = r_v[2];
                n_v[2]  = {r_v[1][1:0], r_v[1][31:2]};
                n_v[1]  = r_v[0];
                n_v[0]  = tmp;
                n_round = r_round + 1'b1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_round = '0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_oidx  = '0;
                n_state = r_finish ? S_OUT : S_LOAD;
            end
            S_OUT: begin
                if (i_tready) begin
                    if (r_oidx == sha1_pkg::LAST_INDEX) begin
                        n_h      = sha1_pkg::IV;
                        n_bitlen = '0;
                        n_fill   = '0;
                        n_finish = 1'b0;
                        n_state  = S_LOAD;
                    end else begin
                        n_oidx = r_oidx + 1'b1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign win_shift = push || (r_state == S_ROUND);
    assign win_in    = push ? push_word : sched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_phase  <= PH_NONE;
            r_fill   <= '0;
            r_round  <= '0;
            r_bitlen <= '0;
            r_finish <= 1'b0;
            r_oidx   <= '0;
            r_h      <= sha1_pkg::IV;
            r_v      <= '{default: '0};
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_round  <= n_round;
            r_bitlen <= n_bitlen;
            r_finish <= n_finish;
            r_oidx   <= n_oidx;
            r_h      <= n_h;
            r_v      <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= win_in;
        end
    end

    assign o_tvalid = (r_state == S_OUT);
    assign o_tdata  = r_h[r_oidx];
    assign o_tuser  = r_oidx;
    assign o_tlast  = (r_oidx == sha1_pkg::LAST_INDEX);

endmodule

FILE: rtl/core/sha1_checker.sv
`timescale 1ns / 1ps

module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // A stalled digest word holds its value and position.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("digest word changed while stalled");

    // The fifth word, and only that one, is marked last.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == 3'd4)))
        else $error("last flag not on the fifth digest word");

    // The digest words come back to back in order.
    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && (o_m_axis_tuser == $past(o_m_axis_tuser) + 3'd1))
        else $error("digest word out of order");

    // Reset leaves no digest word pending.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind sha1_message_digest_unit sha1_checker u_sha1_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

FILE: bench/sha1_message_digest_unit_test.sv
`timescale 1ns / 1ps

module sha1_message_digest_unit_test;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] message_word
    logic [2:0]  i_s_axis_tuser = '0;   // [2:0] valid_bytes
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [31:0] digest_word
    logic [2:0]  o_m_axis_tuser;        // [2:0] word_index
    logic        o_m_axis_tlast;

    sha1_message_digest_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predicted hash state, advanced on every accepted input item.
    logic [31:0]  chain_state [5];
    logic [31:0]  block_words [16];
    logic [3:0]   block_fill;
    logic [63:0]  message_bits;
    t_digest_word digests_due [$];

    int error_count;
    int items_sent;
    int messages_hashed;
    int digest_words_checked;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void clear_hash_state();
        for (int i = 0; i < 5; i++) begin
            chain_state[i] = sha1_pkg::IV[i];
        end
        message_bits = '0;
        block_fill = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        e = chain_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                w = block_words[r];
            end else begin
                w = rotl(block_words[(r - 3) & 15] ^ block_words[(r - 8) & 15] ^
                         block_words[(r - 14) & 15] ^ block_words[r & 15], 1);
                block_words[r & 15] = w;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            t = rotl(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_state[0] += a;
        chain_state[1] += b;
        chain_state[2] += c;
        chain_state[3] += d;
        chain_state[4] += e;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        block_words[block_fill] = w;
        block_fill = block_fill + 4'd1;
        if (block_fill == 4'd0) begin
            compress_block();
        end
    endfunction

    function automatic void hash_item(input logic [31:0] w, input logic [2:0] nbytes,
                                      input logic fin);
        logic [2:0]   used;
        logic [31:0]  keep;
        t_digest_word dw;
        if (!fin) begin
            // Valid byte count only matters on the final word.
            message_bits += 64'd32;
            absorb_word(w);
        end else begin
            used = (nbytes > 3'd4) ? 3'd4 : nbytes;
            message_bits += 64'(used) * 64'd8;
            if (used == 3'd4) begin
                absorb_word(w);
                absorb_word(sha1_pkg::PAD_WORD);
            end else begin
                keep = (used == 3'd0) ? 32'h0 : (32'hffffffff << (32 - 8 * used));
                absorb_word((w & keep) | (sha1_pkg::PAD_WORD >> (8 * used)));
            end
            while (block_fill != sha1_pkg::LEN_HI_SLOT) begin
                absorb_word(32'h0);
            end
            absorb_word(message_bits[63:32]);
            absorb_word(message_bits[31:0]);
            for (int i = 0; i < 5; i++) begin
                dw.digest = chain_state[i];
                dw.index = 3'(i);
                dw.last = (i == 4);
                digests_due.push_back(dw);
            end
            messages_hashed++;
            clear_hash_state();
        end
    endfunction

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digest_word want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                hash_item(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (digests_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected digest item, expected none, actual %h %0d %b",
                             $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                end else begin
                    want = digests_due.pop_front();
                    digest_words_checked++;
                    report_field("digest_word", want.digest, o_m_axis_tdata);
                    report_field("word_index", 32'(want.index), 32'(o_m_axis_tuser));
                    report_field("last_of_digest", 32'(want.last), 32'(o_m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d digest words outstanding", $time,
                     digests_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic [31:0] w, input logic [2:0] nbytes, input logic fin);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= w;
        i_s_axis_tuser <= nbytes;
        i_s_axis_tlast <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Full words carry a random byte count, which the block must ignore.
    task automatic send_message(input int full_words, input logic [2:0] tail_bytes);
        for (int i = 0; i < full_words; i++) begin
            send_item($urandom, 3'($urandom_range(7)), 1'b0);
        end
        send_item($urandom, tail_bytes, 1'b1);
    endtask

    task automatic test_final_word_forms();
        send_item(32'hffffffff, 3'd0, 1'b1);   // empty message, stale bytes masked
        send_item(32'h00000000, 3'd4, 1'b1);
        send_item(32'hffffffff, 3'd1, 1'b1);
        send_item(32'hffffffff, 3'd2, 1'b1);
        send_item(32'hffffffff, 3'd3, 1'b1);
        send_item(32'hffffffff, 3'd4, 1'b1);
        send_item(32'h61626364, 3'd7, 1'b1);   // oversized count clamps to four
        send_item(32'h12345678, 3'd0, 1'b0);   // count ignored on a middle word
        send_item(32'h9abcdef0, 3'd5, 1'b1);
    endtask

    // 55 bytes: the length still fits in the same block as the marker byte.
    task automatic test_pad_boundary();
        send_message(13, 3'd3);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int budget);
        int stop_at;
        int words;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0: words = $urandom_range(28, 40);
                1: words = 13 + $urandom_range(2);
                default: words = $urandom_range(0, 20);
            endcase
            send_message(words, 3'($urandom_range(7)));
        end
    endtask

    initial begin
        error_count = 0;
        items_sent = 0;
        messages_hashed = 0;
        digest_words_checked = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        clear_hash_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_final_word_forms();
        test_pad_boundary();
        test_random_traffic(0, 0, 35);
        test_random_traffic(50, 0, 35);
        test_random_traffic(0, 50, 35);
        test_random_traffic(19, 19, 35);

        i_s_axis_tvalid <= 1'b0;
        while (digests_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages from %0d input items and checked %0d digest words,",
                 messages_hashed, items_sent, digest_words_checked);
        $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_front.sv
rtl/core/sha1_fifo.sv
rtl/core/sha1_engine.sv
rtl/core/sha1_message_digest_unit.sv
rtl/core/sha1_checker.sv
bench/sha1_message_digest_unit_test.sv
